>>> hw/rtl/lgs_pkg.sv
// Shared widths, command codes and constants for the life grid block.
`default_nettype none

package lgs_pkg;

   localparam int CMD_W     = 2;
   localparam int COL_W     = 6;
   localparam int ROW_W     = 6;
   localparam int SIZE_W    = 7;
   localparam int CSR_IDX_W = 1;

   localparam int DEF_MAX_COLUMNS = 64;
   localparam int DEF_MAX_ROWS    = 64;

   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   // B3/S23 neighbor counts
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

endpackage

`default_nettype wire

>>> hw/rtl/lgs_if.sv
// Request and response channel interfaces.
`default_nettype none

interface lgs_req_if import lgs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [COL_W-1:0] column;
   logic [ROW_W-1:0] row;
   logic             cell_value;

   modport source (output valid, output command, output column, output row,
                   output cell_value, input ready);
   modport sink   (input valid, input command, input column, input row,
                   input cell_value, output ready);
endinterface

interface lgs_rsp_if ();
   logic valid;
   logic ready;
   logic cell_alive;
   logic out_of_range;

   modport source (output valid, output cell_alive, output out_of_range, input ready);
   modport sink   (input valid, input cell_alive, input out_of_range, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/lgs_row_unit.sv
// Next-generation rule for one grid row, from the rows above, at and below it.
`default_nettype none

module lgs_row_unit import lgs_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
   input  wire logic [MAX_COLUMNS-1:0]         up_row,
   input  wire logic [MAX_COLUMNS-1:0]         mid_row,
   input  wire logic [MAX_COLUMNS-1:0]         down_row,
   input  wire logic [$clog2(MAX_COLUMNS+1)-1:0] width,
   output logic      [MAX_COLUMNS-1:0]         new_row
);

   localparam int CI_W = $clog2(MAX_COLUMNS);
   localparam int CW   = $clog2(MAX_COLUMNS + 1);

   logic [CI_W-1:0] last_col;
   logic            up_last;
   logic            mid_last;
   logic            down_last;

   assign last_col  = CI_W'(width - CW'(1));
   assign up_last   = up_row[last_col];
   assign mid_last  = mid_row[last_col];
   assign down_last = down_row[last_col];

   for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_col
      logic       ul, ur, ml, mr, dl, dr;
      logic [3:0] cnt;

      // left neighbor wraps to the last column in use
      if (c == 0) begin : g_left_wrap
         assign ul = up_last;
         assign ml = mid_last;
         assign dl = down_last;
      end else begin : g_left
         assign ul = up_row[c-1];
         assign ml = mid_row[c-1];
         assign dl = down_row[c-1];
      end

      if (c == MAX_COLUMNS - 1) begin : g_right_end
         assign ur = up_row[0];
         assign mr = mid_row[0];
         assign dr = down_row[0];
      end else begin : g_right
         logic wrap;
         assign wrap = (CW'(c + 1) == width);
         assign ur   = wrap ? up_row[0]   : up_row[c+1];
         assign mr   = wrap ? mid_row[0]  : mid_row[c+1];
         assign dr   = wrap ? down_row[0] : down_row[c+1];
      end

      assign cnt = 4'(ul) + 4'(up_row[c]) + 4'(ur) + 4'(ml) + 4'(mr)
                 + 4'(dl) + 4'(down_row[c]) + 4'(dr);

      // columns beyond the width in use keep their value
      assign new_row[c] = (CW'(c) < width)
                        ? ((cnt == BIRTH_COUNT) || (mid_row[c] && (cnt == SURVIVE_COUNT)))
                        : mid_row[c];
   end

endmodule

`default_nettype wire

>>> hw/rtl/life_grid_generation_step.sv
// Top level: toroidal life grid with cell access and generation sweep.
//
//   channel   dir   handshake        payload
//   req       in    valid / ready    command, column, row, cell_value
//   rsp       out   valid / ready    cell_alive, out_of_range
//   csr       in    csr_wr_en        csr_index, csr_data
//
// Cell write or read: accept, then the cell state, then the done state; out of
// range or unused command: straight to done. Advance: the sweep of one row word
// per cycle through the single grid RAM port pair covers every row in use.
// After reset a clearing pass writes every row before the first request is
// taken. req.ready is high only while idle; a finished result waits in the
// output register while the next request is taken.
`default_nettype none

module life_grid_generation_step import lgs_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   lgs_req_if.sink                   req,
   lgs_rsp_if.source                 rsp,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SIZE_W-1:0]    csr_data
);

   localparam int CI_W = $clog2(MAX_COLUMNS);
   localparam int CW   = $clog2(MAX_COLUMNS + 1);
   localparam int RA_W = $clog2(MAX_ROWS);
   localparam int HW   = $clog2(MAX_ROWS + 1);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_CELL, S_GEN_UP, S_GEN_MID, S_GEN_ROW, S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [RA_W-1:0]      row_ff, row_in;
   logic [SIZE_W-1:0]    width_ff, width_in;
   logic [SIZE_W-1:0]    height_ff, height_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic                 val_ff, val_in;
   logic [MAX_COLUMNS-1:0] up_ff, up_in;
   logic [MAX_COLUMNS-1:0] mid_ff, mid_in;
   logic [MAX_COLUMNS-1:0] first_ff, first_in;
   logic                 res_alive_ff, res_alive_in;
   logic                 res_oor_ff, res_oor_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_alive_ff, rsp_alive_in;
   logic                 rsp_oor_ff, rsp_oor_in;

   logic [CW-1:0]          w_eff;
   logic [HW-1:0]          h_eff;
   logic                   accept;
   logic                   req_oor;
   logic                   row_last;
   logic [MAX_COLUMNS-1:0] down_row;
   logic [MAX_COLUMNS-1:0] new_row;
   logic [RA_W-1:0]        top_addr;
   logic [RA_W-1:0]        ahead_addr;

   logic                   wr_en;
   logic [RA_W-1:0]        wr_addr;
   logic [MAX_COLUMNS-1:0] wr_data;
   logic [RA_W-1:0]        rd_addr;
   logic [MAX_COLUMNS-1:0] rd_data;

   lgs_ram #(
      .WIDTH (MAX_COLUMNS),
      .DEPTH (MAX_ROWS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lgs_row_unit #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_rule (
      .up_row   (up_ff),
      .mid_row  (mid_ff),
      .down_row (down_row),
      .width    (w_eff),
      .new_row  (new_row)
   );

   // size registers: zero means one, above the store size saturates
   always_comb begin
      if (width_ff == '0) begin
         w_eff = CW'(1);
      end else if (32'(width_ff) > 32'(MAX_COLUMNS)) begin
         w_eff = CW'(MAX_COLUMNS);
      end else begin
         w_eff = CW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HW'(1);
      end else if (32'(height_ff) > 32'(MAX_ROWS)) begin
         h_eff = HW'(MAX_ROWS);
      end else begin
         h_eff = HW'(height_ff);
      end
   end

   assign req.ready    = (state_ff == S_IDLE);
   assign accept       = req.valid && req.ready;
   assign req_oor      = (32'(req.column) >= 32'(w_eff)) || (32'(req.row) >= 32'(h_eff));
   assign row_last     = ((HW'(row_ff) + HW'(1)) == h_eff);
   // the bottom row wraps to the saved copy of the old top row
   assign down_row     = row_last ? first_ff : rd_data;
   assign top_addr     = RA_W'(h_eff - HW'(1));
   assign ahead_addr   = (((HW+1)'(row_ff) + (HW+1)'(2)) < (HW+1)'(h_eff))
                       ? RA_W'(row_ff + RA_W'(2)) : '0;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.cell_alive   = rsp_alive_ff;
   assign rsp.out_of_range = rsp_oor_ff;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      cmd_in       = cmd_ff;
      col_in       = col_ff;
      val_in       = val_ff;
      up_in        = up_ff;
      mid_in       = mid_ff;
      first_in     = first_ff;
      res_alive_in = res_alive_ff;
      res_oor_in   = res_oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_alive_in = rsp_alive_ff;
      rsp_oor_in   = rsp_oor_ff;
      wr_en        = 1'b0;
      wr_addr      = row_ff;
      wr_data      = '0;
      rd_addr      = row_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            REG_GRID_WIDTH:  width_in  = csr_data;
            REG_GRID_HEIGHT: height_in = csr_data;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (row_ff == RA_W'(MAX_ROWS - 1)) begin
               row_in   = '0;
               state_in = S_IDLE;
            end else begin
               row_in = row_ff + RA_W'(1);
            end
         end
         S_IDLE: begin
            rd_addr = (req.command == CMD_ADVANCE) ? top_addr : RA_W'(req.row);
            if (accept) begin
               cmd_in       = req.command;
               col_in       = req.column;
               val_in       = req.cell_value;
               row_in       = RA_W'(req.row);
               res_alive_in = 1'b0;
               res_oor_in   = 1'b0;
               priority if (req.command == CMD_ADVANCE) begin
                  state_in = S_GEN_UP;
               end else if (req.command == CMD_WRITE || req.command == CMD_READ) begin
                  if (req_oor) begin
                     res_oor_in = 1'b1;
                     state_in   = S_DONE;
                  end else begin
                     state_in = S_CELL;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_CELL: begin
            if (cmd_ff == CMD_WRITE) begin
               wr_en                  = 1'b1;
               wr_data                = rd_data;
               wr_data[CI_W'(col_ff)] = val_ff;
            end else begin
               res_alive_in = rd_data[CI_W'(col_ff)];
            end
            state_in = S_DONE;
         end
         S_GEN_UP: begin
            up_in    = rd_data;
            rd_addr  = '0;
            state_in = S_GEN_MID;
         end
         S_GEN_MID: begin
            mid_in   = rd_data;
            first_in = rd_data;
            rd_addr  = (h_eff > HW'(1)) ? RA_W'(1) : '0;
            row_in   = '0;
            state_in = S_GEN_ROW;
         end
         S_GEN_ROW: begin
            // old rows are held in the window, so the new row goes back in place
            wr_en   = 1'b1;
            wr_data = new_row;
            rd_addr = ahead_addr;
            up_in   = mid_ff;
            mid_in  = down_row;
            if (row_last) begin
               state_in = S_DONE;
            end else begin
               row_in = row_ff + RA_W'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_alive_in = res_alive_ff;
               rsp_oor_in   = res_oor_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         row_ff       <= '0;
         width_ff     <= SIZE_RESET;
         height_ff    <= SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      col_ff       <= col_in;
      val_ff       <= val_in;
      up_ff        <= up_in;
      mid_ff       <= mid_in;
      first_ff     <= first_in;
      res_alive_ff <= res_alive_in;
      res_oor_ff   <= res_oor_in;
      rsp_alive_ff <= rsp_alive_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

endmodule

`default_nettype wire
